/* rtl/core/lfs_pkg.sv */
package lfs_pkg;

	// Command codes carried in the cmd field
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_ON   = 2'd1;
	localparam logic [1:0] CMD_OFF  = 2'd2;
	localparam logic [1:0] CMD_LOAD = 2'd3;

	// Register indexes on the APB port (byte address / 4)
	localparam logic REG_SEQ_LEN = 1'b0;
	localparam logic REG_PAUSE   = 1'b1;

	localparam int SEQ_LEN_W  = 5;
	localparam int PAUSE_W    = 8;
	localparam int ENTRY_W    = 4;
	localparam int PHASE_W    = 3;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Input transaction
	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  entry_index;
		logic [31:0] entry_pattern;
		logic [7:0]  entry_flashes;
		logic [7:0]  entry_on_ticks;
		logic [7:0]  entry_off_ticks;
	} in_item_t;

	// Result transaction
	typedef struct packed {
		logic [31:0] shown_pattern;
		logic        refresh;
		logic [2:0]  phase;
		logic [3:0]  entry_now;
	} out_item_t;

	// One pattern table slot
	typedef struct packed {
		logic [31:0] pattern;
		logic [7:0]  flashes;
		logic [7:0]  on_ticks;
		logic [7:0]  off_ticks;
	} slot_t;

endpackage

/* rtl/core/led_flash_sequencer.sv */
// Path: an accepted transaction lands in the input register; the combinational machine pass
// writes its result into the output register once that register can take it.
// Throughput: one transaction per cycle while out_stall does not hold the output register.
// Reset: phase idle, entry pointer, counters and pattern cleared, sequence_length 1,
// repeat_pause 0. The pattern table is not cleared; slots are undefined until loaded.
module led_flash_sequencer #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  lfs_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output lfs_pkg::out_item_t               out_data,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lfs_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lfs_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lfs_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import lfs_pkg::*;

	// Longest playable sequence and slots reachable by a 4-bit load index
	localparam int LEN_MAX = (TABLE_DEPTH < 31) ? TABLE_DEPTH : 31;
	localparam int SLOTS   = (TABLE_DEPTH < 16) ? TABLE_DEPTH : 16;
	localparam int PTR_W   = (LEN_MAX > 1) ? $clog2(LEN_MAX) : 1;
	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CMP_W   = SEQ_LEN_W + 1;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_START  = 3'd1,
		PH_ON     = 3'd2,
		PH_OFF    = 3'd3,
		PH_REPEAT = 3'd4,
		PH_STOP   = 3'd5
	} phase_t;

	// Configuration registers
	logic [SEQ_LEN_W-1:0] seq_len_q;
	logic [PAUSE_W-1:0]   pause_q;

	// Sequencer state
	phase_t         phase_q;
	logic [PTR_W-1:0] ptr_q;
	logic [7:0]     flash_cnt_q;
	logic [7:0]     tick_q;
	logic [31:0]    pattern_q;
	logic [7:0]     cur_flashes_q;
	logic [7:0]     cur_off_q;
	slot_t          table_q [SLOTS];

	// Input and output registers
	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_data_q;

	logic advance;

	// Next-state values from one machine pass
	phase_t         phase_n;
	logic [PTR_W-1:0] ptr_n;
	logic [7:0]     flash_cnt_n;
	logic [7:0]     tick_n;
	logic [31:0]    pattern_n;
	logic [7:0]     cur_flashes_n;
	logic [7:0]     cur_off_n;
	logic           refresh_n;
	logic           do_begin;
	logic           is_load;
	slot_t          rd_slot;
	logic [SEQ_LEN_W-1:0] eff_len;
	logic [7:0]     fc_inc;
	logic [CMP_W-1:0] ptr_inc;

	// APB port: always ready, registers at 0 and 4
	assign pready = 1'b1;

	always_comb begin
		if (paddr[2] == REG_SEQ_LEN) begin
			prdata = APB_DATA_W'(seq_len_q);
		end else begin
			prdata = APB_DATA_W'(pause_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q <= SEQ_LEN_W'(1);
			pause_q   <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_SEQ_LEN) begin
				seq_len_q <= pwdata[SEQ_LEN_W-1:0];
			end else begin
				pause_q <= pwdata[PAUSE_W-1:0];
			end
		end
	end

	// Handshake: input register moves on whenever the output register can take it
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// Effective sequence length: zero acts as one, limited by the table depth
	always_comb begin
		eff_len = seq_len_q;
		if (eff_len == '0) begin
			eff_len = SEQ_LEN_W'(1);
		end
		if (32'(eff_len) > LEN_MAX) begin
			eff_len = SEQ_LEN_W'(LEN_MAX);
		end
	end

	assign is_load = (item_s1.cmd == CMD_LOAD) && (32'(item_s1.entry_index) < TABLE_DEPTH);

	// One machine pass: command first, then the phase step
	always_comb begin
		phase_n       = phase_q;
		ptr_n         = ptr_q;
		flash_cnt_n   = flash_cnt_q;
		tick_n        = tick_q;
		pattern_n     = pattern_q;
		cur_flashes_n = cur_flashes_q;
		cur_off_n     = cur_off_q;
		refresh_n     = 1'b0;
		do_begin      = 1'b0;
		fc_inc        = flash_cnt_q + 8'd1;
		ptr_inc       = CMP_W'(ptr_q) + CMP_W'(1);

		// command
		case (item_s1.cmd)
			CMD_TICK: begin
				if (tick_q != 8'd0) begin
					tick_n = tick_q - 8'd1;
				end
			end
			CMD_ON:  phase_n = PH_START;
			CMD_OFF: phase_n = PH_STOP;
			CMD_LOAD: begin
				if (phase_q != PH_IDLE && phase_q != PH_STOP) begin
					phase_n = PH_START;
				end
			end
			default: ;
		endcase

		// phase step; pointer is settled before the slot is read
		case (phase_n)
			PH_IDLE: ;
			PH_START: begin
				ptr_n       = '0;
				flash_cnt_n = '0;
				do_begin    = 1'b1;
			end
			PH_ON, PH_OFF: begin
				if (tick_n == 8'd0) begin
					if (phase_n == PH_ON && cur_off_q != 8'd0) begin
						// go dark for the off time
						pattern_n = '0;
						phase_n   = PH_OFF;
						tick_n    = cur_off_q;
						refresh_n = 1'b1;
					end else begin
						// flash ends
						flash_cnt_n = fc_inc;
						if (fc_inc == cur_flashes_q) begin
							flash_cnt_n = '0;
							ptr_inc     = ptr_inc;
						end else begin
							ptr_inc = CMP_W'(ptr_q);
						end
						if (ptr_inc >= CMP_W'(eff_len)) begin
							ptr_n = '0;
							if (pause_q == '0) begin
								do_begin = 1'b1;
							end else begin
								tick_n  = pause_q;
								phase_n = PH_REPEAT;
							end
						end else begin
							ptr_n    = PTR_W'(ptr_inc);
							do_begin = 1'b1;
						end
					end
				end
			end
			PH_REPEAT: begin
				if (tick_n == 8'd0) begin
					do_begin = 1'b1;
				end
			end
			default: begin
				phase_n   = PH_IDLE;
				pattern_n = '0;
				refresh_n = 1'b1;
			end
		endcase

		// slot read, with the load of this same transaction forwarded
		rd_slot = table_q[ptr_n[IDX_W-1:0]];
		if (is_load && 32'(item_s1.entry_index) == 32'(ptr_n)) begin
			rd_slot.pattern   = item_s1.entry_pattern;
			rd_slot.flashes   = item_s1.entry_flashes;
			rd_slot.on_ticks  = item_s1.entry_on_ticks;
			rd_slot.off_ticks = item_s1.entry_off_ticks;
		end

		// entry begins
		if (do_begin) begin
			tick_n        = rd_slot.on_ticks;
			pattern_n     = rd_slot.pattern;
			cur_flashes_n = rd_slot.flashes;
			cur_off_n     = rd_slot.off_ticks;
			phase_n       = PH_ON;
			refresh_n     = 1'b1;
		end
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			ptr_q       <= '0;
			flash_cnt_q <= '0;
			tick_q      <= '0;
			pattern_q   <= '0;
		end else if (advance) begin
			phase_q     <= phase_n;
			ptr_q       <= ptr_n;
			flash_cnt_q <= flash_cnt_n;
			tick_q      <= tick_n;
			pattern_q   <= pattern_n;
		end
	end

	// Cached flash count and off time of the entry in play
	always_ff @(posedge clk) begin
		if (advance) begin
			cur_flashes_q <= cur_flashes_n;
			cur_off_q     <= cur_off_n;
		end
	end

	// Pattern table
	always_ff @(posedge clk) begin
		if (advance && is_load) begin
			table_q[item_s1.entry_index[IDX_W-1:0]] <= {item_s1.entry_pattern,
				item_s1.entry_flashes, item_s1.entry_on_ticks, item_s1.entry_off_ticks};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.shown_pattern <= pattern_n;
			out_data_q.refresh       <= refresh_n;
			out_data_q.phase         <= phase_n;
			out_data_q.entry_now     <= ENTRY_W'(ptr_n);
		end
	end

	// A dark phase always shows a blank pattern
	a_dark_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_data_q.phase == PH_OFF || out_data_q.phase == PH_IDLE))
		|-> (out_data_q.shown_pattern == '0))
		else $error("dark phase with non-blank pattern");

	// The entry in play stays inside the longest playable sequence
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ON || phase_q == PH_OFF) |-> (CMP_W'(ptr_q) < CMP_W'(LEN_MAX)))
		else $error("entry pointer beyond table");

	// Input is held back only while a finished result waits
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall && valid_s1))
		else $error("input stalled without a waiting result");

	// A result that is not a refresh keeps the previous pattern
	a_refresh_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !refresh_n) |-> (pattern_n == pattern_q))
		else $error("pattern changed without refresh");

endmodule
